// ----- rtl/core/fmf_pkg.sv -----
// Shared types, constants and codes for the FIX message framer.
// Used by fmf_cfg, fmf_step and fix_message_framer_unit.
`timescale 1ns / 1ps
`default_nettype none

package fmf_pkg;

  localparam int BEGIN_MAX_BYTES   = 16;
  localparam int LENGTH_MAX_DIGITS = 9;

  localparam logic [7:0]  SOH_BYTE     = 8'h01;
  localparam logic [7:0]  ZERO_CHAR    = 8'h30;
  localparam logic [7:0]  ONE_CHAR     = 8'h31;
  localparam logic [7:0]  EQUALS_CHAR  = 8'h3D;
  localparam logic [23:0] MIN_BODY_LEN = 24'd20;
  localparam logic [23:0] TRAILER_LEN  = 24'd7;
  localparam logic [23:0] LEN_SAT      = 24'hFF_FFFF;

  localparam logic [4:0]  BEGIN_LEN_RESET = 5'd1;
  localparam logic [23:0] MAX_BODY_RESET  = 24'd65535;

  typedef enum logic [1:0] {
    REG_BEGIN_LOW  = 2'd0,
    REG_BEGIN_HIGH = 2'd1,
    REG_BEGIN_LEN  = 2'd2,
    REG_MAX_BODY   = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_BODY    = 2'd2,
    PH_TRAILER = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_PROGRESS     = 3'd0,
    ST_OK           = 3'd1,
    ST_BAD_BEGIN    = 3'd2,
    ST_BAD_LENGTH   = 3'd3,
    ST_BAD_TRAILER  = 3'd4,
    ST_BAD_CHECKSUM = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    TAG_NONE    = 4'd0,
    TAG_BEGIN   = 4'd8,
    TAG_LENGTH  = 4'd9,
    TAG_TRAILER = 4'd10
  } tag_t;

  typedef struct packed {
    logic [127:0] begin_bytes;
    logic [4:0]   begin_length;
    logic [23:0]  max_body_length;
  } cfg_t;

  typedef struct packed {
    phase_t       phase;
    logic [23:0]  byte_count;
    logic [7:0]   running_sum;
    logic [23:0]  length_accum;
    logic         length_overflow;
    logic         header_mismatch;
    logic [55:0]  trailer_bytes;
  } frame_state_t;

  localparam frame_state_t STATE_RESET = '{
    phase:           PH_HEADER,
    byte_count:      24'd0,
    running_sum:     8'd0,
    length_accum:    24'd0,
    length_overflow: 1'b0,
    header_mismatch: 1'b0,
    trailer_bytes:   56'd0
  };

  typedef struct packed {
    logic [7:0]  data_out;
    phase_t      phase;
    logic        in_body;
    logic        msg_end;
    status_t     status;
    tag_t        error_tag;
    logic [23:0] frame_length;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/fmf_cfg.sv -----
// Configuration register file of the FIX message framer.
// Depends on fmf_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module fmf_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic [1:0]    wr_index,
  input  wire logic [63:0]   wr_data,
  output fmf_pkg::cfg_t      cfg
);
  import fmf_pkg::*;

  logic [63:0] begin_low;
  logic [63:0] begin_high;
  logic [4:0]  begin_length;
  logic [23:0] max_body_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      begin_low       <= 64'd0;
      begin_high      <= 64'd0;
      begin_length    <= BEGIN_LEN_RESET;
      max_body_length <= MAX_BODY_RESET;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_BEGIN_LOW:  begin_low       <= wr_data;
        REG_BEGIN_HIGH: begin_high      <= wr_data;
        REG_BEGIN_LEN:  begin_length    <= wr_data[4:0];
        REG_MAX_BODY:   max_body_length <= wr_data[23:0];
        default:        ;
      endcase
    end
  end

  assign cfg.begin_bytes     = {begin_high, begin_low};
  assign cfg.begin_length    = begin_length;
  assign cfg.max_body_length = max_body_length;

endmodule

`default_nettype wire

// ----- rtl/core/fmf_step.sv -----
// Per-byte framing logic: next message state and result for one byte.
// Depends on fmf_pkg for state, result and configuration types.
`timescale 1ns / 1ps
`default_nettype none

module fmf_step (
  input  wire fmf_pkg::cfg_t         cfg,
  input  wire fmf_pkg::frame_state_t st,
  input  wire logic [7:0]            in_byte,
  output fmf_pkg::frame_state_t      st_next,
  output fmf_pkg::result_t           res
);
  import fmf_pkg::*;

  logic [23:0] count_inc;
  logic [7:0]  sum_inc;
  logic [4:0]  eff_len;
  logic [7:0]  expected;
  logic        is_digit;
  logic [7:0]  digit_raw;
  logic [27:0] accum_x10;
  logic [27:0] accum_new;
  logic [55:0] trail_new;
  logic [7:0]  d2;
  logic [7:0]  d1;
  logic [7:0]  d0;
  logic [9:0]  trail_sum;
  logic        end_msg;
  frame_state_t nxt;

  assign count_inc = st.byte_count + 24'd1;
  assign sum_inc   = st.running_sum + in_byte;

  always_comb begin
    if (cfg.begin_length == 5'd0) begin
      eff_len = 5'd1;
    end else if (cfg.begin_length > 5'(BEGIN_MAX_BYTES)) begin
      eff_len = 5'(BEGIN_MAX_BYTES);
    end else begin
      eff_len = cfg.begin_length;
    end
  end

  assign expected  = cfg.begin_bytes[{st.byte_count[3:0], 3'b000} +: 8];
  assign digit_raw = in_byte - ZERO_CHAR;
  assign is_digit  = (in_byte >= ZERO_CHAR) && (digit_raw <= 8'd9);
  assign accum_x10 = {1'b0, st.length_accum, 3'b000} + {3'b000, st.length_accum, 1'b0};
  assign accum_new = accum_x10 + {24'd0, digit_raw[3:0]};

  assign trail_new = {st.trailer_bytes[47:0], in_byte};
  assign d2 = trail_new[31:24] - ZERO_CHAR;
  assign d1 = trail_new[23:16] - ZERO_CHAR;
  assign d0 = trail_new[15:8]  - ZERO_CHAR;
  assign trail_sum = 10'(d2[3:0]) * 10'd100 + 10'(d1[3:0]) * 10'd10 + 10'(d0[3:0]);

  always_comb begin
    nxt              = st;
    end_msg          = 1'b0;
    res.data_out     = in_byte;
    res.phase        = st.phase;
    res.in_body      = (st.phase == PH_BODY);
    res.status       = ST_PROGRESS;
    res.error_tag    = TAG_NONE;
    res.frame_length = 24'd0;

    unique case (st.phase)
      PH_HEADER: begin
        nxt.running_sum = sum_inc;
        nxt.byte_count  = count_inc;
        if (in_byte != expected) begin
          nxt.header_mismatch = 1'b1;
        end
        if (count_inc >= {19'd0, eff_len}) begin
          if (nxt.header_mismatch) begin
            end_msg       = 1'b1;
            res.status    = ST_BAD_BEGIN;
            res.error_tag = TAG_BEGIN;
          end else begin
            nxt.phase      = PH_LENGTH;
            nxt.byte_count = 24'd0;
          end
        end
      end
      PH_LENGTH: begin
        nxt.running_sum = sum_inc;
        nxt.byte_count  = count_inc;
        if (in_byte == SOH_BYTE) begin
          if (count_inc < 24'd2 || st.length_overflow || st.length_accum < MIN_BODY_LEN) begin
            end_msg          = 1'b1;
            res.status       = ST_BAD_LENGTH;
            res.error_tag    = TAG_LENGTH;
            res.frame_length = st.length_accum;
          end else begin
            nxt.phase      = PH_BODY;
            nxt.byte_count = 24'd0;
          end
        end else begin
          if (is_digit) begin
            if (accum_new > {4'd0, cfg.max_body_length}) begin
              nxt.length_overflow = 1'b1;
            end
            nxt.length_accum = (accum_new > {4'd0, LEN_SAT}) ? LEN_SAT : accum_new[23:0];
          end else begin
            nxt.length_overflow = 1'b1;
          end
          if (count_inc >= 24'(LENGTH_MAX_DIGITS + 1)) begin
            end_msg          = 1'b1;
            res.status       = ST_BAD_LENGTH;
            res.error_tag    = TAG_LENGTH;
            res.frame_length = nxt.length_accum;
          end
        end
      end
      PH_BODY: begin
        nxt.running_sum = sum_inc;
        nxt.byte_count  = count_inc;
        if (count_inc >= st.length_accum) begin
          if (in_byte != SOH_BYTE) begin
            end_msg          = 1'b1;
            res.status       = ST_BAD_LENGTH;
            res.error_tag    = TAG_LENGTH;
            res.frame_length = st.length_accum;
          end else begin
            nxt.phase         = PH_TRAILER;
            nxt.byte_count    = 24'd0;
            nxt.trailer_bytes = 56'd0;
          end
        end
      end
      PH_TRAILER: begin
        nxt.trailer_bytes = trail_new;
        nxt.byte_count    = count_inc;
        if (count_inc >= TRAILER_LEN) begin
          end_msg          = 1'b1;
          res.error_tag    = TAG_TRAILER;
          res.frame_length = st.length_accum;
          if (trail_new[55:48] != ONE_CHAR || trail_new[47:40] != ZERO_CHAR ||
              trail_new[39:32] != EQUALS_CHAR || trail_new[7:0] != SOH_BYTE) begin
            res.status = ST_BAD_TRAILER;
          end else if (d2 <= 8'd9 && d1 <= 8'd9 && d0 <= 8'd9 &&
                       {2'b00, st.running_sum} == trail_sum) begin
            res.status    = ST_OK;
            res.error_tag = TAG_NONE;
          end else begin
            res.status = ST_BAD_CHECKSUM;
          end
        end
      end
      default: ;
    endcase

    res.msg_end = end_msg;
    st_next     = end_msg ? STATE_RESET : nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/fix_message_framer_unit.sv -----
// FIX message framer: top level with input register, message state and result register.
// Depends on fmf_pkg, fmf_cfg and fmf_step.
//
// Takes one stream byte per transaction and returns exactly one result per byte:
// the byte itself, its message phase (header, length, body, trailer), and on the
// byte that completes or aborts a message the status, failing FIX tag and parsed
// body length. Throughput is one byte per clock while the result is not stalled; a
// byte is held in the input register, passes the state update in the single step
// between the input register and the result register, and its result is offered once
// it is registered. Input stalls only while both registers hold a transaction and
// the result is stalled. Write configuration only while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module fix_message_framer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [63:0] wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       data_out,
  output logic [1:0]       phase,
  output logic             in_body,
  output logic             msg_end,
  output logic [2:0]       status,
  output logic [3:0]       error_tag,
  output logic [23:0]      frame_length
);
  import fmf_pkg::*;

  cfg_t         cfg;
  frame_state_t state;
  frame_state_t state_next;
  result_t      step_res;
  result_t      res;
  logic         stage_valid;
  logic [7:0]   stage_byte;
  logic         out_free;
  logic         advance;
  logic         accept;

  fmf_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  fmf_step u_step (
    .cfg     (cfg),
    .st      (state),
    .in_byte (stage_byte),
    .st_next (state_next),
    .res     (step_res)
  );

  assign out_free = !out_valid || !out_stall;
  assign advance  = stage_valid && out_free;
  assign in_stall = stage_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
      state       <= STATE_RESET;
    end else begin
      if (accept) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_byte <= in_byte;
    end
    if (advance) begin
      res <= step_res;
    end
  end

  assign data_out     = res.data_out;
  assign phase        = res.phase;
  assign in_body      = res.in_body;
  assign msg_end      = res.msg_end;
  assign status       = res.status;
  assign error_tag    = res.error_tag;
  assign frame_length = res.frame_length;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for fix_message_framer_unit: framed FIX streams, good and broken.
// Holds a byte-level predictor of the framer inside a small scoreboard class.
// Depends on fmf_pkg and the framer RTL.
`timescale 1ns / 1ps

module tb_top;
  import fmf_pkg::*;

  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         DRAIN_CYCLES = 4;
  localparam logic [7:0] NINE_CHAR    = 8'h39;

  typedef logic [7:0] byte_q_t[$];

  typedef enum {
    MSG_GOOD, MSG_NOISE, MSG_FLIPPED, MSG_BAD_BEGIN, MSG_BAD_CHECKSUM, MSG_BAD_TRAILER,
    MSG_NONDIGIT_LEN, MSG_SHORT_LEN, MSG_LONG_LEN, MSG_MANY_DIGITS, MSG_EMPTY_LEN,
    MSG_BODY_MISS
  } msg_kind_t;

  class framer_scoreboard;
    logic [127:0] begin_bytes = '0;
    logic [4:0]   begin_len   = BEGIN_LEN_RESET;
    logic [23:0]  max_len     = MAX_BODY_RESET;
    frame_state_t st          = STATE_RESET;
    result_t      expected_q[$];
    int unsigned  mismatches  = 0;

    function int header_span();
      if (begin_len == 5'd0) return 1;
      if (begin_len > 5'(BEGIN_MAX_BYTES)) return BEGIN_MAX_BYTES;
      return int'(begin_len);
    endfunction

    function void write_reg(reg_index_t idx, logic [63:0] data);
      case (idx)
        REG_BEGIN_LOW:  begin_bytes[63:0]   = data;
        REG_BEGIN_HIGH: begin_bytes[127:64] = data;
        REG_BEGIN_LEN:  begin_len           = data[4:0];
        REG_MAX_BODY:   max_len             = data[23:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      result_t     r;
      logic [63:0] v;
      logic [7:0]  d2, d1, d0;
      int          sent_sum;
      r.data_out     = b;
      r.phase        = st.phase;
      r.in_body      = (st.phase == PH_BODY);
      r.msg_end      = 1'b0;
      r.status       = ST_PROGRESS;
      r.error_tag    = TAG_NONE;
      r.frame_length = 24'd0;
      case (st.phase)
        PH_HEADER: begin
          st.running_sum = st.running_sum + b;
          if (b != begin_bytes[{st.byte_count[3:0], 3'b000} +: 8]) st.header_mismatch = 1'b1;
          st.byte_count = st.byte_count + 24'd1;
          if (st.byte_count >= 24'(header_span())) begin
            if (st.header_mismatch) begin
              r.msg_end   = 1'b1;
              r.status    = ST_BAD_BEGIN;
              r.error_tag = TAG_BEGIN;
            end else begin
              st.phase      = PH_LENGTH;
              st.byte_count = 24'd0;
            end
          end
        end
        PH_LENGTH: begin
          st.running_sum = st.running_sum + b;
          st.byte_count  = st.byte_count + 24'd1;
          if (b == SOH_BYTE) begin
            if (st.byte_count < 24'd2 || st.length_overflow
                || st.length_accum < MIN_BODY_LEN) begin
              r.msg_end      = 1'b1;
              r.status       = ST_BAD_LENGTH;
              r.error_tag    = TAG_LENGTH;
              r.frame_length = st.length_accum;
            end else begin
              st.phase      = PH_BODY;
              st.byte_count = 24'd0;
            end
          end else begin
            if (b >= ZERO_CHAR && b <= NINE_CHAR) begin
              v = st.length_accum * 64'd10 + 64'(b - ZERO_CHAR);
              if (v > 64'(max_len)) st.length_overflow = 1'b1;
              if (v > 64'(LEN_SAT)) v = 64'(LEN_SAT);
              st.length_accum = v[23:0];
            end else begin
              st.length_overflow = 1'b1;
            end
            if (st.byte_count >= 24'(LENGTH_MAX_DIGITS + 1)) begin
              r.msg_end      = 1'b1;
              r.status       = ST_BAD_LENGTH;
              r.error_tag    = TAG_LENGTH;
              r.frame_length = st.length_accum;
            end
          end
        end
        PH_BODY: begin
          st.running_sum = st.running_sum + b;
          st.byte_count  = st.byte_count + 24'd1;
          if (st.byte_count >= st.length_accum) begin
            if (b != SOH_BYTE) begin
              r.msg_end      = 1'b1;
              r.status       = ST_BAD_LENGTH;
              r.error_tag    = TAG_LENGTH;
              r.frame_length = st.length_accum;
            end else begin
              st.phase         = PH_TRAILER;
              st.byte_count    = 24'd0;
              st.trailer_bytes = 56'd0;
            end
          end
        end
        default: begin
          st.trailer_bytes = {st.trailer_bytes[47:0], b};
          st.byte_count    = st.byte_count + 24'd1;
          if (st.byte_count >= TRAILER_LEN) begin
            r.msg_end      = 1'b1;
            r.error_tag    = TAG_TRAILER;
            r.frame_length = st.length_accum;
            if (st.trailer_bytes[55:48] != ONE_CHAR || st.trailer_bytes[47:40] != ZERO_CHAR
                || st.trailer_bytes[39:32] != EQUALS_CHAR
                || st.trailer_bytes[7:0] != SOH_BYTE) begin
              r.status = ST_BAD_TRAILER;
            end else begin
              d2 = st.trailer_bytes[31:24] - ZERO_CHAR;
              d1 = st.trailer_bytes[23:16] - ZERO_CHAR;
              d0 = st.trailer_bytes[15:8] - ZERO_CHAR;
              sent_sum = int'(d2) * 100 + int'(d1) * 10 + int'(d0);
              if (d2 <= 8'd9 && d1 <= 8'd9 && d0 <= 8'd9
                  && sent_sum == int'(st.running_sum)) begin
                r.status    = ST_OK;
                r.error_tag = TAG_NONE;
              end else begin
                r.status = ST_BAD_CHECKSUM;
              end
            end
          end
        end
      endcase
      if (r.msg_end) st = STATE_RESET;
      expected_q.push_back(r);
    endfunction

    function void report_mismatch(string why, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t %s: expected byte %h phase %0d body %0b end %0b status %0d tag %0d len %0d",
                 $realtime, why, want.data_out, want.phase, want.in_body, want.msg_end,
                 want.status, want.error_tag, want.frame_length);
        $display("%0t %s: actual   byte %h phase %0d body %0b end %0b status %0d tag %0d len %0d",
                 $realtime, why, got.data_out, got.phase, got.in_body, got.msg_end,
                 got.status, got.error_tag, got.frame_length);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.data_out !== want.data_out || got.phase !== want.phase
          || got.in_body !== want.in_body || got.msg_end !== want.msg_end
          || got.status !== want.status || got.error_tag !== want.error_tag
          || got.frame_length !== want.frame_length)
        report_mismatch("field mismatch", want, got);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        wr_en;
  reg_index_t  wr_index;
  logic [63:0] wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  data_out;
  logic [1:0]  phase;
  logic        in_body;
  logic        msg_end;
  logic [2:0]  status;
  logic [3:0]  error_tag;
  logic [23:0] frame_length;

  framer_scoreboard sb;
  int unsigned      idle_pct = 0;
  int unsigned      stall_pct = 0;
  int               bytes_sent = 0;
  int               cycles = 0;

  fix_message_framer_unit i_dut (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .data_out(data_out), .phase(phase), .in_body(in_body), .msg_end(msg_end),
    .status(status), .error_tag(error_tag), .frame_length(frame_length)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99, 0) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (wr_en) sb.write_reg(wr_index, wr_data);
      if (in_valid && !in_stall) sb.note_byte(in_byte);
      if (out_valid && !out_stall)
        sb.check_result(result_t'({data_out, phase, in_body, msg_end, status, error_tag,
                                   frame_length}));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic byte_q_t decimal_text(int unsigned value, int width);
    byte_q_t d;
    do begin
      d.push_front(8'(ZERO_CHAR + value % 10));
      value = value / 10;
    end while (value != 0);
    while (d.size() < width) d.push_front(ZERO_CHAR);
    return d;
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] c;
    c = 8'($urandom);
    while ((c >= ZERO_CHAR && c <= NINE_CHAR) || c == SOH_BYTE) c = 8'($urandom);
    return c;
  endfunction

  task automatic reg_write(input reg_index_t idx, input logic [63:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [63:0] low, input logic [63:0] high,
                              input logic [4:0] len, input logic [23:0] max_body);
    reg_write(REG_BEGIN_LOW, low);
    reg_write(REG_BEGIN_HIGH, high);
    reg_write(REG_BEGIN_LEN, ({$urandom, $urandom} & ~64'h1F) | 64'(len));
    reg_write(REG_MAX_BODY, ({$urandom, $urandom} & ~64'hFF_FFFF) | 64'(max_body));
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // len_value and len_width below zero pick them at random
  task automatic send_message(input msg_kind_t kind, input int len_value, input int len_width);
    byte_q_t    m;
    byte_q_t    digits;
    byte_q_t    trailer;
    int         blen, hi, hs, le, span, pos, ck, k;
    logic [7:0] sum;
    if (kind == MSG_NOISE) begin
      k = $urandom_range(12, 3);
      repeat (k) m.push_back(8'($urandom));
    end else begin
      for (int i = 0; i < sb.header_span(); i++) m.push_back(sb.begin_bytes[8*i +: 8]);
      hs = m.size();
      hi = (sb.max_len < 24'd40) ? int'(sb.max_len) : 40;
      if (len_value >= 0) blen = len_value;
      else if (kind == MSG_SHORT_LEN) blen = $urandom_range(int'(MIN_BODY_LEN) - 1, 0);
      else if (kind == MSG_LONG_LEN)
        blen = (sb.max_len == LEN_SAT) ? 99999999 : int'(sb.max_len) + 1 + $urandom_range(5, 0);
      else blen = $urandom_range(hi, int'(MIN_BODY_LEN));
      if (len_width < 0) begin
        if (kind == MSG_MANY_DIGITS) len_width = $urandom_range(12, LENGTH_MAX_DIGITS + 1);
        else len_width = ($urandom_range(3, 0) == 0) ? $urandom_range(LENGTH_MAX_DIGITS, 1) : 0;
      end
      digits = decimal_text(blen, len_width);
      if (kind == MSG_NONDIGIT_LEN) digits.insert($urandom_range(digits.size(), 0), non_digit());
      if (kind == MSG_EMPTY_LEN) digits = {};
      m = {m, digits};
      m.push_back(SOH_BYTE);
      le = m.size();
      if (!(kind inside {MSG_NONDIGIT_LEN, MSG_SHORT_LEN, MSG_LONG_LEN, MSG_MANY_DIGITS,
                         MSG_EMPTY_LEN})) begin
        repeat (blen - 1) m.push_back(8'($urandom));
        m.push_back((kind == MSG_BODY_MISS) ? non_digit() : SOH_BYTE);
        if (kind != MSG_BODY_MISS) begin
          sum = 8'd0;
          foreach (m[i]) sum = sum + m[i];
          ck = int'(sum);
          if (kind == MSG_BAD_CHECKSUM && $urandom_range(1, 0) == 1)
            ck = (ck + $urandom_range(999, 1)) % 1000;
          trailer = {ONE_CHAR, ZERO_CHAR, EQUALS_CHAR};
          trailer = {trailer, decimal_text(ck, 3)};
          trailer.push_back(SOH_BYTE);
          if (kind == MSG_BAD_CHECKSUM && ck == int'(sum))
            trailer[$urandom_range(5, 3)] = non_digit();
          if (kind == MSG_BAD_TRAILER) begin
            k = $urandom_range(3, 0);
            pos = (k == 3) ? 6 : k;
            trailer[pos] = trailer[pos] ^ 8'($urandom_range(255, 1));
          end
          m = {m, trailer};
        end
        if (kind == MSG_FLIPPED) begin
          span = le - hs;
          pos = $urandom_range(m.size() - 1 - span, 0);
          if (pos >= hs) pos += span;
          m[pos] = m[pos] ^ 8'($urandom_range(255, 1));
        end
      end
      if (kind == MSG_BAD_BEGIN) begin
        pos = $urandom_range(hs - 1, 0);
        m[pos] = m[pos] ^ 8'($urandom_range(255, 1));
      end
    end
    foreach (m[i]) send_byte(m[i]);
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall, input int n,
                           input bit hold_mid);
    int        target;
    int        r;
    bit        held;
    msg_kind_t kind;
    idle_pct  = idle;
    stall_pct = stall;
    target    = bytes_sent + n;
    held      = 1'b0;
    while (bytes_sent < target) begin
      r = $urandom_range(99, 0);
      if (r < 58) kind = MSG_GOOD;
      else if (r < 64) kind = MSG_NOISE;
      else if (r < 71) kind = MSG_FLIPPED;
      else if (r < 75) kind = MSG_BAD_BEGIN;
      else if (r < 81) kind = MSG_BAD_CHECKSUM;
      else if (r < 85) kind = MSG_BAD_TRAILER;
      else if (r < 88) kind = MSG_NONDIGIT_LEN;
      else if (r < 91) kind = MSG_SHORT_LEN;
      else if (r < 94) kind = MSG_LONG_LEN;
      else if (r < 96) kind = MSG_MANY_DIGITS;
      else if (r < 98) kind = MSG_EMPTY_LEN;
      else kind = MSG_BODY_MISS;
      send_message(kind, -1, -1);
      if (hold_mid && !held && bytes_sent >= target - n / 2) begin
        wait_drain();
        held = 1'b1;
      end
    end
    wait_drain();
  endtask

  initial begin
    sb = new();
    rst       <= 1'b1;
    wr_en     <= 1'b0;
    wr_index  <= REG_BEGIN_LOW;
    wr_data   <= 64'd0;
    in_valid  <= 1'b0;
    in_byte   <= 8'd0;
    out_stall <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: one zero header byte, default length limit
    send_message(MSG_GOOD, 20, 0);
    wait_drain();

    program_regs(64'h2E34_2E58_4946_3D38, 64'h0000_0000_3D39_0134, 5'd12, MIN_BODY_LEN);
    send_message(MSG_GOOD, 20, 0);
    send_message(MSG_GOOD, 20, LENGTH_MAX_DIGITS);
    send_message(MSG_BAD_CHECKSUM, -1, -1);
    send_message(MSG_BAD_CHECKSUM, -1, -1);
    send_message(MSG_BAD_TRAILER, -1, -1);
    send_message(MSG_BAD_BEGIN, -1, -1);
    send_message(MSG_NONDIGIT_LEN, -1, -1);
    send_message(MSG_SHORT_LEN, 19, 0);
    send_message(MSG_LONG_LEN, 21, 0);
    send_message(MSG_MANY_DIGITS, 20, LENGTH_MAX_DIGITS + 1);
    send_message(MSG_EMPTY_LEN, -1, -1);
    send_message(MSG_BODY_MISS, -1, -1);
    send_message(MSG_NOISE, -1, -1);
    send_message(MSG_GOOD, -1, -1);
    wait_drain();

    program_regs(64'h2E34_2E58_4946_3D38, 64'h0000_0000_3D39_0134, 5'd12, LEN_SAT);
    send_message(MSG_LONG_LEN, -1, 0);
    send_message(MSG_GOOD, -1, -1);
    wait_drain();

    program_regs({$urandom, $urandom}, {$urandom, $urandom}, 5'd0, LEN_SAT);
    run_phase(0, 0, 20, 1'b0);
    program_regs({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, MIN_BODY_LEN);
    run_phase(71, 0, 20, 1'b0);
    program_regs({$urandom, $urandom}, {$urandom, $urandom}, 5'd31,
                 24'($urandom_range(200, 20)));
    run_phase(0, 71, 20, 1'b1);
    program_regs(64'hFFFF_FFFF_FFFF_FFFF, {$urandom, $urandom}, 5'($urandom_range(15, 2)),
                 24'($urandom_range(int'(LEN_SAT), 20)));
    run_phase(19, 19, 20, 1'b0);
    program_regs(64'h2E34_2E58_4946_3D38, 64'h0000_0000_3D39_0134, 5'd12, 24'd40);
    run_phase(0, 0, 20, 1'b0);

    repeat (10) @(posedge clk);
    if (sb.expected_q.size() != 0) sb.mismatches++;
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
